// ===== rtl/sftp_pkg.sv =====
// Package for the framed telegram parser: phase codes, sync constants, word layout.
package sftp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hA5;
    localparam logic [7:0] SYNC_SECOND = 8'h5A;
    localparam logic [2:0] GROUP_BYTES = 3'd4;

    // Parser phase, one-hot
    typedef enum logic [7:0] {
        PH_SYNC1  = 8'b0000_0001,
        PH_SYNC2  = 8'b0000_0010,
        PH_TYPE   = 8'b0000_0100,
        PH_ORIGIN = 8'b0000_1000,
        PH_DATA   = 8'b0001_0000,
        PH_ID     = 8'b0010_0000,
        PH_STATUS = 8'b0100_0000,
        PH_CHECK  = 8'b1000_0000
    } phase_t;

    // Binary phase numbers as they appear on the result word
    localparam logic [2:0] CODE_SYNC1  = 3'd0;
    localparam logic [2:0] CODE_SYNC2  = 3'd1;
    localparam logic [2:0] CODE_TYPE   = 3'd2;
    localparam logic [2:0] CODE_ORIGIN = 3'd3;
    localparam logic [2:0] CODE_DATA   = 3'd4;
    localparam logic [2:0] CODE_ID     = 3'd5;
    localparam logic [2:0] CODE_STATUS = 3'd6;
    localparam logic [2:0] CODE_CHECK  = 3'd7;

    localparam int RES_BITS  = 91;
    localparam int RES_BYTES = (RES_BITS + 7) / 8;
    localparam int TDATA_W   = RES_BYTES * 8;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] c;
        begin
            case (ph)
                PH_SYNC1:  c = CODE_SYNC1;
                PH_SYNC2:  c = CODE_SYNC2;
                PH_TYPE:   c = CODE_TYPE;
                PH_ORIGIN: c = CODE_ORIGIN;
                PH_DATA:   c = CODE_DATA;
                PH_ID:     c = CODE_ID;
                PH_STATUS: c = CODE_STATUS;
                PH_CHECK:  c = CODE_CHECK;
                default:   c = CODE_SYNC1;
            endcase
            return c;
        end
    endfunction

    // Write byte b into the slot of w (slot = remaining count - 1, so 4 -> bits 31..24)
    function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] slot,
                                             input logic [7:0] b);
        logic [4:0]  sh;
        logic [31:0] mask;
        begin
            sh   = {slot, 3'b000};
            mask = 32'h0000_00FF << sh;
            return (w & ~mask) | ({24'b0, b} << sh);
        end
    endfunction

endpackage

// ===== rtl/sync_framed_telegram_parser.sv =====
// Framed serial telegram parser: sync hunt, field capture and checksum check.
// Each result word is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless the sink stalls; the whole per-byte update is one short
//   combinational step from the state registers into the result register.
// The output register frees itself in the cycle it is taken, so a stalled
//   sink only holds off the source while m_tvalid is high and m_tready low.
// Reset (aresetn low, synchronous): sync1 hunt, all holds and sum cleared.
module sync_framed_telegram_parser
    import sftp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // input byte stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] rx_byte
    // result stream, one word per input byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [2:0] parse_phase, [10:3] telegram_type,
                                          // [18:11] origin_code, [50:19] payload_word,
                                          // [82:51] sender_word, [90:83] status_code,
                                          // [95:91] zero
    output logic               m_tuser    // frame_good
);

    phase_t      phase_reg,   phase_next;
    logic [2:0]  left_reg,    left_next;
    logic [7:0]  sum_reg,     sum_next;
    logic [7:0]  type_reg,    type_next;
    logic [7:0]  origin_reg,  origin_next;
    logic [31:0] payload_reg, payload_next;
    logic [31:0] sender_reg,  sender_next;
    logic [7:0]  status_reg,  status_next;
    logic        good_next;

    logic               out_valid_reg;
    logic [TDATA_W-1:0] out_data_reg;
    logic               out_good_reg;

    logic       accept;
    logic [2:0] left_eff;   // group counter, out-of-range values treated as one
    logic [1:0] slot;

    // Output register empties when taken, so a new byte can enter every cycle while the sink takes words
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        case (left_reg) inside
            3'd1, 3'd2, 3'd3, 3'd4: left_eff = left_reg;
            default:                left_eff = 3'd1;
        endcase
    end
    assign slot = 2'(left_eff - 3'd1);

    // Per-byte parser step
    always_comb begin
        phase_next   = phase_reg;
        left_next    = left_reg;
        sum_next     = sum_reg;
        type_next    = type_reg;
        origin_next  = origin_reg;
        payload_next = payload_reg;
        sender_next  = sender_reg;
        status_next  = status_reg;
        good_next    = 1'b0;

        // only type through status bytes enter the checksum
        if (phase_reg == PH_TYPE || phase_reg == PH_ORIGIN || phase_reg == PH_DATA ||
            phase_reg == PH_ID || phase_reg == PH_STATUS) begin
            sum_next = sum_reg + s_tdata;
        end

        case (phase_reg)
            PH_SYNC1: begin
                if (s_tdata == SYNC_FIRST) begin
                    sum_next   = 8'd0;
                    phase_next = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                // a wrong second sync byte is dropped, not re-tested as a first
                phase_next = (s_tdata == SYNC_SECOND) ? PH_TYPE : PH_SYNC1;
            end
            PH_TYPE: begin
                type_next  = s_tdata;
                phase_next = PH_ORIGIN;
            end
            PH_ORIGIN: begin
                origin_next = s_tdata;
                left_next   = GROUP_BYTES;
                phase_next  = PH_DATA;
            end
            PH_DATA: begin
                payload_next = put_byte(payload_reg, slot, s_tdata);
                if (left_eff == 3'd1) begin
                    left_next  = GROUP_BYTES;
                    phase_next = PH_ID;
                end else begin
                    left_next = left_eff - 3'd1;
                end
            end
            PH_ID: begin
                sender_next = put_byte(sender_reg, slot, s_tdata);
                left_next   = left_eff - 3'd1;
                if (left_eff == 3'd1) begin
                    phase_next = PH_STATUS;
                end
            end
            PH_STATUS: begin
                status_next = s_tdata;
                phase_next  = PH_CHECK;
            end
            PH_CHECK: begin
                phase_next = PH_SYNC1;
                good_next  = (sum_reg == s_tdata);
            end
            default: begin
                phase_next = PH_SYNC1;
            end
        endcase
    end

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SYNC1;
            left_reg    <= 3'd0;
            sum_reg     <= 8'd0;
            type_reg    <= 8'd0;
            origin_reg  <= 8'd0;
            payload_reg <= 32'd0;
            sender_reg  <= 32'd0;
            status_reg  <= 8'd0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            sum_reg     <= sum_next;
            type_reg    <= type_next;
            origin_reg  <= origin_next;
            payload_reg <= payload_next;
            sender_reg  <= sender_next;
            status_reg  <= status_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_good_reg <= good_next;
            out_data_reg <= {(TDATA_W - RES_BITS)'(0), status_next, sender_next,
                             payload_next, origin_next, type_next, phase_code(phase_next)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_good_reg;

endmodule
